/* sv/gwca_pkg.sv */
// Shared constants, types and the exp lookup table for the weighted color average.
// No dependencies.
package gwca_pkg;

  localparam int WEIGHT_FRAC_BITS = 16;
  localparam int EXP_TABLE_SIZE   = 64;
  localparam int TAB_IDX_W        = $clog2(EXP_TABLE_SIZE);
  localparam int EXP_W            = 31;
  localparam int SUM_W            = 35;
  localparam int WT_W             = 27;
  localparam int W_W              = WEIGHT_FRAC_BITS + 1;
  localparam int DIST_W           = 16;
  localparam int COLOR_W          = 8;
  localparam int INV_W            = 24;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 24;
  localparam int DIV_BITS         = 8;
  localparam int DIV_CNT_W        = $clog2(DIV_BITS);

  localparam logic [CFG_IDX_W-1:0] REG_INV_TWO_SIGMA_SQ = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE     = 2'd1;

  localparam logic [INV_W-1:0]  INV_RESET  = 24'd65536;
  localparam logic [DIST_W-1:0] MAXD_RESET = 16'd65535;

  // Taylor series step, Q.30
  localparam longint unsigned EXP_STEP = (64'd1 << 34) / EXP_TABLE_SIZE;

  typedef logic [EXP_W-1:0] exp_tab_t [0:EXP_TABLE_SIZE];

  typedef struct packed {
    logic                 load_in;
    logic                 acc;
    logic                 div_init;
    logic                 div_step;
    logic [DIV_CNT_W-1:0] div_bit;
    logic                 out_load;
  } gwca_cmd_t;

  typedef struct packed {
    logic item_last;
    logic out_busy;
  } gwca_status_t;

  // shift-subtract quotient, used only while the table is built
  function automatic longint unsigned udiv_shift(longint unsigned n, longint unsigned dv);
    longint unsigned q;
    longint unsigned rm;
    q  = 64'd0;
    rm = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rm = (rm << 1) | ((n >> b) & 64'd1);
      if (rm >= dv) begin
        rm = rm - dv;
        q  = q | (64'd1 << b);
      end
    end
    return q;
  endfunction

  function automatic exp_tab_t build_exp_tab();
    exp_tab_t        t;
    longint unsigned h;
    longint unsigned term;
    longint unsigned r;
    longint unsigned prev;
    longint          acc;
    h    = EXP_STEP;
    term = 64'd1 << 30;
    acc  = longint'(64'd1 << 30);
    for (int k = 1; k <= 24; k++) begin
      term = udiv_shift((term * h) >> 30, longint'(k));
      if ((k & 1) != 0) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    r = (acc < 0) ? 64'd0 : longint'(acc);
    prev = 64'd1 << 30;
    t[0] = EXP_W'(prev);
    for (int k = 1; k <= EXP_TABLE_SIZE; k++) begin
      prev = (prev * r + (64'd1 << 29)) >> 30;
      t[k] = EXP_W'(prev);
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

/* sv/gwca_ctrl.sv */
// Sequencer for the weighted color average: item steps, divide steps, result load.
// Depends on gwca_pkg.
module gwca_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  gwca_pkg::gwca_status_t status,
  output gwca_pkg::gwca_cmd_t    cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQ    = 4'd1;
  localparam logic [3:0] S_XM    = 4'd2;
  localparam logic [3:0] S_TAB   = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_ACC   = 4'd5;
  localparam logic [3:0] S_DINIT = 4'd6;
  localparam logic [3:0] S_DSTEP = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0]                    state, state_next;
  logic [gwca_pkg::DIV_CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    cmd          = '0;
    cmd.div_bit  = cnt;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_SQ;
        end
      end
      S_SQ:  state_next = S_XM;
      S_XM:  state_next = S_TAB;
      S_TAB: state_next = S_MUL;
      S_MUL: state_next = S_ACC;
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = status.item_last ? S_DINIT : S_IDLE;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_next     = gwca_pkg::DIV_CNT_W'(gwca_pkg::DIV_BITS - 1);
        state_next   = S_DSTEP;
      end
      S_DSTEP: begin
        cmd.div_step = 1'b1;
        if (cnt == '0) state_next = S_OUT;
        else cnt_next = cnt - 1'b1;
      end
      S_OUT: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* sv/gwca_dp.sv */
// Datapath: config registers, weight pipeline, accumulators, divider, result register.
// Depends on gwca_pkg.
module gwca_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  gwca_pkg::gwca_cmd_t                  cmd,
  output gwca_pkg::gwca_status_t               status,
  input  logic                                cfg_we,
  input  logic [gwca_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gwca_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                op,
  input  logic [gwca_pkg::DIST_W-1:0]         geodesic_distance,
  input  logic [gwca_pkg::COLOR_W-1:0]        color_ch0,
  input  logic [gwca_pkg::COLOR_W-1:0]        color_ch1,
  input  logic [gwca_pkg::COLOR_W-1:0]        color_ch2,
  input  logic                                last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [gwca_pkg::COLOR_W-1:0]        out_ch0,
  output logic [gwca_pkg::COLOR_W-1:0]        out_ch1,
  output logic [gwca_pkg::COLOR_W-1:0]        out_ch2,
  output logic                                saturated
);

  localparam int SUM_W  = gwca_pkg::SUM_W;
  localparam int WT_W   = gwca_pkg::WT_W;
  localparam int EXP_W  = gwca_pkg::EXP_W;
  localparam int W_W    = gwca_pkg::W_W;
  localparam int CW     = gwca_pkg::COLOR_W;
  localparam int IW     = gwca_pkg::TAB_IDX_W;
  localparam int X_W    = 2 * gwca_pkg::DIST_W + gwca_pkg::INV_W;
  localparam int XL_W   = 36;
  localparam int P_W    = XL_W + IW + 1;
  localparam int PR_W   = EXP_W + 16;
  localparam int M_W    = CW + W_W;
  localparam int SH     = 30 - gwca_pkg::WEIGHT_FRAC_BITS;
  localparam int DV_W   = SUM_W + 1;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [WT_W-1:0]  WT_MAX  = {WT_W{1'b1}};

  logic [gwca_pkg::INV_W-1:0]  inv_r;
  logic [gwca_pkg::DIST_W-1:0] maxd_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_r  <= gwca_pkg::INV_RESET;
      maxd_r <= gwca_pkg::MAXD_RESET;
    end else if (cfg_we) begin
      if (cfg_index == gwca_pkg::REG_INV_TWO_SIGMA_SQ) inv_r <= cfg_data;
      else if (cfg_index == gwca_pkg::REG_MAX_DISTANCE)
        maxd_r <= cfg_data[gwca_pkg::DIST_W-1:0];
    end
  end

  // input item hold
  logic                        op_r, last_r, skip_r;
  logic [gwca_pkg::DIST_W-1:0] d_r;
  logic [CW-1:0]               c0_r, c1_r, c2_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r   <= op;
      last_r <= last;
      skip_r <= geodesic_distance > maxd_r;
      d_r    <= geodesic_distance;
      c0_r   <= color_ch0;
      c1_r   <= color_ch1;
      c2_r   <= color_ch2;
    end
  end

  // weight pipeline
  logic [2*gwca_pkg::DIST_W-1:0] dsq_r;
  logic [X_W-1:0]                x_r;
  logic [P_W-1:0]                p;
  logic [IW:0]                   idx_a, idx_b;
  logic [EXP_W-1:0]              ta, tb;
  logic [EXP_W-1:0]              a_r;
  logic [PR_W-1:0]               prod_r;
  logic                          zero_r;
  logic [EXP_W-1:0]              e;
  logic [W_W-1:0]                w;
  logic [W_W-1:0]                w_r;
  logic [M_W-1:0]                m0_r, m1_r, m2_r;

  always_comb begin
    p     = P_W'((P_W'(x_r[XL_W-1:0]) * P_W'(gwca_pkg::EXP_TABLE_SIZE)) >> 4);
    idx_a = {1'b0, p[32 +: IW]};
    idx_b = idx_a + 1'b1;
    ta    = gwca_pkg::EXP_TAB[idx_a];
    tb    = gwca_pkg::EXP_TAB[idx_b];
    e     = a_r - prod_r[PR_W-1:16];
    w     = zero_r ? '0 : e[SH +: W_W];
  end

  always_ff @(posedge clk) begin
    dsq_r  <= d_r * d_r;
    x_r    <= X_W'(dsq_r) * X_W'(inv_r);
    zero_r <= |x_r[X_W-1:XL_W];
    a_r    <= ta;
    prod_r <= PR_W'(ta - tb) * PR_W'(p[31:16]);
    w_r    <= w;
    m0_r   <= M_W'(c0_r) * M_W'(w);
    m1_r   <= M_W'(c1_r) * M_W'(w);
    m2_r   <= M_W'(c2_r) * M_W'(w);
  end

  // accumulators
  logic [SUM_W-1:0] sum0, sum1, sum2;
  logic [WT_W-1:0]  wt;
  logic             sat_seen;
  logic [SUM_W:0]   a0, a1, a2;
  logic [WT_W:0]    aw;

  assign a0 = (SUM_W+1)'(sum0) + (SUM_W+1)'(m0_r);
  assign a1 = (SUM_W+1)'(sum1) + (SUM_W+1)'(m1_r);
  assign a2 = (SUM_W+1)'(sum2) + (SUM_W+1)'(m2_r);
  assign aw = (WT_W+1)'(wt) + (WT_W+1)'(w_r);

  always_ff @(posedge clk) begin
    if (rst || cmd.out_load) begin
      sum0     <= '0;
      sum1     <= '0;
      sum2     <= '0;
      wt       <= '0;
      sat_seen <= 1'b0;
    end else if (cmd.acc) begin
      if (!op_r) begin
        sum0     <= SUM_W'(c0_r) << gwca_pkg::WEIGHT_FRAC_BITS;
        sum1     <= SUM_W'(c1_r) << gwca_pkg::WEIGHT_FRAC_BITS;
        sum2     <= SUM_W'(c2_r) << gwca_pkg::WEIGHT_FRAC_BITS;
        wt       <= WT_W'(1) << gwca_pkg::WEIGHT_FRAC_BITS;
        sat_seen <= 1'b0;
      end else if (!skip_r) begin
        sum0 <= a0[SUM_W] ? SUM_MAX : a0[SUM_W-1:0];
        sum1 <= a1[SUM_W] ? SUM_MAX : a1[SUM_W-1:0];
        sum2 <= a2[SUM_W] ? SUM_MAX : a2[SUM_W-1:0];
        wt   <= aw[WT_W] ? WT_MAX : aw[WT_W-1:0];
        if (a0[SUM_W] || a1[SUM_W] || a2[SUM_W] || aw[WT_W]) sat_seen <= 1'b1;
      end
    end
  end

  // restoring divide, quotient clamped to 255
  logic [DV_W-1:0] rem0, rem1, rem2;
  logic [CW-1:0]   q0, q1, q2;
  logic            ov0, ov1, ov2;
  logic [DV_W-1:0] wt_top, wt_sh;

  assign wt_top = DV_W'(wt) << gwca_pkg::DIV_BITS;
  assign wt_sh  = DV_W'(wt) << cmd.div_bit;

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem0 <= DV_W'(sum0);
      rem1 <= DV_W'(sum1);
      rem2 <= DV_W'(sum2);
      q0   <= '0;
      q1   <= '0;
      q2   <= '0;
      ov0  <= DV_W'(sum0) >= wt_top;
      ov1  <= DV_W'(sum1) >= wt_top;
      ov2  <= DV_W'(sum2) >= wt_top;
    end else if (cmd.div_step) begin
      if (rem0 >= wt_sh) begin
        rem0 <= rem0 - wt_sh;
        q0[cmd.div_bit] <= 1'b1;
      end
      if (rem1 >= wt_sh) begin
        rem1 <= rem1 - wt_sh;
        q1[cmd.div_bit] <= 1'b1;
      end
      if (rem2 >= wt_sh) begin
        rem2 <= rem2 - wt_sh;
        q2[cmd.div_bit] <= 1'b1;
      end
    end
  end

  // result register
  logic wt_zero;
  assign wt_zero = (wt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ch0   <= wt_zero ? '0 : (ov0 ? {CW{1'b1}} : q0);
      out_ch1   <= wt_zero ? '0 : (ov1 ? {CW{1'b1}} : q1);
      out_ch2   <= wt_zero ? '0 : (ov2 ? {CW{1'b1}} : q2);
      saturated <= sat_seen;
    end
  end

  assign status.item_last = last_r;
  assign status.out_busy  = out_valid && !out_ready;

endmodule

/* sv/gaussian_weighted_color_average_core.sv */
// Gaussian-weighted three-channel color average over a texel's center and neighbors.
// Each item moves from transfer to accumulate through the sequencer states SQ, XM, TAB,
// MUL and ACC; an item with last then runs an 8-step restoring divide and its result load.
// No new item is taken until the previous one is done; a result load waits out a stalled output.
// Reset (rst, synchronous): accumulators cleared, registers to defaults, no result.
module gaussian_weighted_color_average_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            op,
  input  logic [gwca_pkg::DIST_W-1:0]     geodesic_distance,
  input  logic [gwca_pkg::COLOR_W-1:0]    color_ch0,
  input  logic [gwca_pkg::COLOR_W-1:0]    color_ch1,
  input  logic [gwca_pkg::COLOR_W-1:0]    color_ch2,
  input  logic                            last,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [gwca_pkg::COLOR_W-1:0]    out_ch0,
  output logic [gwca_pkg::COLOR_W-1:0]    out_ch1,
  output logic [gwca_pkg::COLOR_W-1:0]    out_ch2,
  output logic                            saturated,
  input  logic                            cfg_we,
  input  logic [gwca_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gwca_pkg::CFG_DATA_W-1:0] cfg_data
);

  gwca_pkg::gwca_cmd_t    cmd;
  gwca_pkg::gwca_status_t status;

  gwca_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  gwca_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .op                (op),
    .geodesic_distance (geodesic_distance),
    .color_ch0         (color_ch0),
    .color_ch1         (color_ch1),
    .color_ch2         (color_ch2),
    .last              (last),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_ch0           (out_ch0),
    .out_ch1           (out_ch1),
    .out_ch2           (out_ch2),
    .saturated         (saturated)
  );

endmodule

/* sv/gwca_checker.sv */
// Port-level checks for the weighted color average core, bound to the top level.
// Depends on gwca_pkg and gaussian_weighted_color_average_core.
module gwca_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            last,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [gwca_pkg::COLOR_W-1:0]    out_ch0,
  input logic [gwca_pkg::COLOR_W-1:0]    out_ch1,
  input logic [gwca_pkg::COLOR_W-1:0]    out_ch2,
  input logic                            saturated
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_ch0) && $stable(out_ch1)
      && $stable(out_ch2) && $stable(saturated))
    else $error("result changed while stalled");

  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after an input transfer");

  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  a_result_needs_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !last |=> !$rose(out_valid))
    else $error("result without a last item");

endmodule

bind gaussian_weighted_color_average_core gwca_checker u_gwca_checker (.*);

/* dv/tb_gaussian_weighted_color_average_core.sv */
// Self-checking testbench for gaussian_weighted_color_average_core: directed,
// register sweep, idle/stall phases and backpressure, checked against an inline predictor.
// Depends on gwca_pkg (register indexes, widths) and the core RTL.
module tb_gaussian_weighted_color_average_core;

  localparam logic OP_CENTER   = 1'b0;
  localparam logic OP_NEIGHBOR = 1'b1;
  localparam logic [gwca_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [gwca_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam longint unsigned ACC_MAX  = (64'd1 << gwca_pkg::SUM_W) - 1;
  localparam longint unsigned WSUM_MAX = (64'd1 << gwca_pkg::WT_W) - 1;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic [7:0] ch0;
    logic [7:0] ch1;
    logic [7:0] ch2;
    logic       sat;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic op = 1'b0;
  logic [gwca_pkg::DIST_W-1:0] geodesic_distance = '0;
  logic [gwca_pkg::COLOR_W-1:0] color_ch0 = '0, color_ch1 = '0, color_ch2 = '0;
  logic last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [gwca_pkg::COLOR_W-1:0] out_ch0, out_ch1, out_ch2;
  logic saturated;
  logic cfg_we = 1'b0;
  logic [gwca_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [gwca_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  gaussian_weighted_color_average_core dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  longint unsigned exp_lut [0:64];
  longint unsigned inv_sigma_q, max_dist_q;
  longint unsigned acc0, acc1, acc2, wsum;
  logic sat_flag;
  pixel_t avg_q [$];

  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  bit hold_rx = 1'b0;
  int items_sent = 0;
  int results_seen = 0;
  int errors = 0;

  function automatic void build_exp_lut();
    longint unsigned step, term, ratio;
    longint acc;
    step = (64'd1 << 34) / 64;
    term = 64'd1 << 30;
    acc = longint'(64'd1 << 30);
    for (int k = 1; k <= 24; k++) begin
      term = ((term * step) >> 30) / longint'(k);
      if (k % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    ratio = (acc < 0) ? 64'd0 : longint'(acc);
    exp_lut[0] = 64'd1 << 30;
    for (int k = 1; k <= 64; k++)
      exp_lut[k] = (exp_lut[k-1] * ratio + (64'd1 << 29)) >> 30;
  endfunction

  function automatic longint unsigned gauss_weight(longint unsigned d);
    longint unsigned x, p, i, f, a, b, e;
    x = d * d * inv_sigma_q;
    if (x >= (64'd16 << 32)) return 0;
    p = (x * 64) >> 4;
    i = p >> 32;
    if (i >= 64) return 0;
    f = (p >> 16) & 64'hFFFF;
    a = exp_lut[i];
    b = exp_lut[i+1];
    e = (a >= b) ? a - (((a - b) * f) >> 16) : a + (((b - a) * f) >> 16);
    return e >> (30 - gwca_pkg::WEIGHT_FRAC_BITS);
  endfunction

  function automatic longint unsigned clamp_add(longint unsigned s, longint unsigned v,
                                                longint unsigned lim);
    if (s > lim || v > lim - s) begin
      sat_flag = 1'b1;
      return lim;
    end
    return s + v;
  endfunction

  function automatic logic [7:0] channel_avg(longint unsigned s);
    longint unsigned q;
    if (wsum == 0) return 8'd0;
    q = s / wsum;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic void clear_texel();
    acc0 = 0; acc1 = 0; acc2 = 0; wsum = 0; sat_flag = 1'b0;
  endfunction

  function automatic void average_step(logic o, longint unsigned d, longint unsigned c0,
                                       longint unsigned c1, longint unsigned c2, logic l);
    longint unsigned w;
    pixel_t px;
    if (o == OP_CENTER) begin
      clear_texel();
      acc0 = c0 << gwca_pkg::WEIGHT_FRAC_BITS;
      acc1 = c1 << gwca_pkg::WEIGHT_FRAC_BITS;
      acc2 = c2 << gwca_pkg::WEIGHT_FRAC_BITS;
      wsum = 64'd1 << gwca_pkg::WEIGHT_FRAC_BITS;
    end else if (d <= max_dist_q) begin
      w = gauss_weight(d);
      acc0 = clamp_add(acc0, c0 * w, ACC_MAX);
      acc1 = clamp_add(acc1, c1 * w, ACC_MAX);
      acc2 = clamp_add(acc2, c2 * w, ACC_MAX);
      wsum = clamp_add(wsum, w, WSUM_MAX);
    end
    if (l) begin
      px.ch0 = channel_avg(acc0);
      px.ch1 = channel_avg(acc1);
      px.ch2 = channel_avg(acc2);
      px.sat = sat_flag;
      avg_q.push_back(px);
      clear_texel();
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    pixel_t px;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (avg_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        px = avg_q.pop_front();
        if (out_ch0 !== px.ch0) report_mismatch("out_ch0", out_ch0, px.ch0);
        if (out_ch1 !== px.ch1) report_mismatch("out_ch1", out_ch1, px.ch1);
        if (out_ch2 !== px.ch2) report_mismatch("out_ch2", out_ch2, px.ch2);
        if (saturated !== px.sat) report_mismatch("saturated", saturated, px.sat);
      end
    end
  end

  // receiver ready, with a counted long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_rx) begin
        out_ready = 1'b0;
        repeat (300) @(negedge clk);
        hold_rx = 1'b0;
      end
      out_ready = ($urandom_range(99) >= snk_stall_pct);
    end
  end

  task automatic send_item(logic o, logic [15:0] d, logic [7:0] c0, logic [7:0] c1,
                           logic [7:0] c2, logic l);
    @(negedge clk);
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid = 1'b0;
      do @(negedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    op = o;
    geodesic_distance = d;
    color_ch0 = c0;
    color_ch1 = c1;
    color_ch2 = c2;
    last = l;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    average_step(o, d, c0, c1, c2, l);
    items_sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    wait (avg_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [gwca_pkg::CFG_IDX_W-1:0] idx,
                           logic [gwca_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == gwca_pkg::REG_INV_TWO_SIGMA_SQ) inv_sigma_q = val;
    else if (idx == gwca_pkg::REG_MAX_DISTANCE) max_dist_q = val[gwca_pkg::DIST_W-1:0];
  endtask

  function automatic logic [15:0] pick_dist();
    case ($urandom_range(3))
      0: return 16'd0;
      1: return 16'($urandom_range(0, 255));
      2: return 16'($urandom_range(0, 1023));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [7:0] pick_color();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic rand_texels(int n);
    int target, nb;
    target = items_sent + n;
    while (items_sent < target) begin
      if ($urandom_range(99) < 15) begin
        send_item(1'($urandom_range(1)), 16'($urandom_range(0, 65535)), pick_color(),
                  pick_color(), pick_color(), 1'($urandom_range(1)));
      end else begin
        nb = $urandom_range(0, 12);
        send_item(OP_CENTER, 16'($urandom_range(0, 65535)), pick_color(), pick_color(),
                  pick_color(), nb == 0);
        for (int k = 0; k < nb; k++)
          send_item(OP_NEIGHBOR, pick_dist(), pick_color(), pick_color(), pick_color(),
                    k == nb - 1);
      end
    end
  endtask

  task automatic test_directed();
    send_item(OP_CENTER, 16'hFFFF, 8'd0, 8'd128, 8'd255, 1'b1);
    send_item(OP_CENTER, 16'h0000, 8'd255, 8'd255, 8'd255, 1'b1);
    send_item(OP_CENTER, 16'h0000, 8'd10, 8'd20, 8'd30, 1'b0);
    send_item(OP_NEIGHBOR, 16'd0, 8'd250, 8'd0, 8'd100, 1'b0);
    send_item(OP_NEIGHBOR, 16'd256, 8'd255, 8'd255, 8'd0, 1'b0);
    send_item(OP_NEIGHBOR, 16'hFFFF, 8'd255, 8'd255, 8'd255, 1'b1);
    // neighbor before any center, alone
    send_item(OP_NEIGHBOR, 16'd128, 8'd200, 8'd50, 8'd7, 1'b1);
    // zero total weight
    send_item(OP_NEIGHBOR, 16'hFFFF, 8'd99, 8'd99, 8'd99, 1'b1);
    settle();
    write_reg(gwca_pkg::REG_MAX_DISTANCE, 24'd256);
    send_item(OP_CENTER, 16'd0, 8'd1, 8'd2, 8'd3, 1'b0);
    send_item(OP_NEIGHBOR, 16'd255, 8'd200, 8'd200, 8'd200, 1'b0);
    send_item(OP_NEIGHBOR, 16'd256, 8'd100, 8'd100, 8'd100, 1'b0);
    send_item(OP_NEIGHBOR, 16'd257, 8'd255, 8'd255, 8'd255, 1'b1); // skipped, still emits
    send_item(OP_NEIGHBOR, 16'd300, 8'd255, 8'd255, 8'd255, 1'b1); // skipped, zero weight
    settle();
    write_reg(REG_SPARE_A, 24'hFFFFFF);
    write_reg(REG_SPARE_B, 24'd0);
    write_reg(gwca_pkg::REG_MAX_DISTANCE, 24'd65535);
    send_item(OP_CENTER, 16'd0, 8'd40, 8'd50, 8'd60, 1'b0);
    send_item(OP_NEIGHBOR, 16'd1000, 8'd255, 8'd0, 8'd255, 1'b1);
    settle();
  endtask

  task automatic test_register_sweep();
    logic [23:0] inv_set [6];
    logic [23:0] maxd_set [6];
    inv_set = '{24'd0, 24'hFFFFFF, 24'd65536, 24'd1, 24'd4096, 24'd0};
    maxd_set = '{24'd65535, 24'd0, 24'd1023, 24'd65535, 24'd0, 24'd0};
    inv_set[5] = 24'($urandom_range(0, 24'hFFFFFF));
    maxd_set[5] = 24'($urandom_range(0, 65535));
    for (int s = 0; s < 6; s++) begin
      write_reg(gwca_pkg::REG_INV_TWO_SIGMA_SQ, inv_set[s]);
      write_reg(gwca_pkg::REG_MAX_DISTANCE, maxd_set[s]);
      rand_texels(120);
      settle();
    end
    write_reg(gwca_pkg::REG_INV_TWO_SIGMA_SQ, gwca_pkg::INV_RESET);
    write_reg(gwca_pkg::REG_MAX_DISTANCE, 24'(gwca_pkg::MAXD_RESET));
  endtask

  task automatic test_idle_phases();
    int src_mode [4];
    int snk_mode [4];
    src_mode = '{0, 73, 0, 7};
    snk_mode = '{0, 0, 73, 7};
    for (int p = 0; p < 4; p++) begin
      src_idle_pct = src_mode[p];
      snk_stall_pct = snk_mode[p];
      rand_texels(190);
    end
    src_idle_pct = 0;
    snk_stall_pct = 0;
    settle();
  endtask

  task automatic test_backpressure();
    hold_rx = 1'b1;
    for (int k = 0; k < 60; k++)
      send_item(OP_CENTER, 16'd0, pick_color(), pick_color(), pick_color(), 1'b1);
    settle();
  endtask

  initial begin
    build_exp_lut();
    inv_sigma_q = gwca_pkg::INV_RESET;
    max_dist_q = gwca_pkg::MAXD_RESET;
    clear_texel();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_register_sweep();
    test_idle_phases();
    test_backpressure();
    $display("run covered %0d transfers in, %0d results checked, %0d mismatches",
             items_sent, results_seen, errors);
    $display("tests: directed, register sweep, idle phases, backpressure");
    if (errors == 0)
      $display("[gaussian_weighted_color_average_core] OK");
    else
      $display("[gaussian_weighted_color_average_core] ERROR");
    $finish;
  end

  initial begin
    #4000000;
    $display("[gaussian_weighted_color_average_core] ERROR");
    $finish;
  end

endmodule

/* files.f */
sv/gwca_pkg.sv
sv/gwca_ctrl.sv
sv/gwca_dp.sv
sv/gaussian_weighted_color_average_core.sv
sv/gwca_checker.sv
dv/tb_gaussian_weighted_color_average_core.sv
